// ===== rtl/segx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg
// Types, widths and helpers shared by the segment intersection core.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int CoordW        = 16;
  localparam int DiffW         = CoordW + 1;
  localparam int ProdW         = 2 * DiffW;
  localparam int DenW          = ProdW + 1;
  localparam int NumW          = DenW + DiffW;
  localparam int QuotW         = CoordW + 1;
  localparam int SumW          = QuotW + 2;
  localparam int QueueDepthDef = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [DenW-1:0]   den_t;
  typedef logic signed [NumW-1:0]   num_t;

  typedef struct packed {
    coord_t start1_x;
    coord_t start1_y;
    coord_t end1_x;
    coord_t end1_y;
    coord_t start2_x;
    coord_t start2_y;
    coord_t end2_x;
    coord_t end2_y;
  } segx_in_t;

  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t cross_x;
    coord_t cross_y;
    logic   clipped;
  } segx_out_t;

  // classified pair handed from front to back
  typedef struct packed {
    logic   hit;
    logic   parallel;
    den_t   den;
    den_t   na;
    diff_t  d1x;
    diff_t  d1y;
    coord_t ax;
    coord_t ay;
  } segx_job_t;

  // 0 <= num/den <= 1 for nonzero den
  function automatic logic in_unit(den_t num, den_t den);
    logic r;
    if (den > 0) begin
      r = (num >= 0) && (num <= den);
    end else begin
      r = (num <= 0) && (num >= den);
    end
    return r;
  endfunction

endpackage

// ===== rtl/segx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_front
// Forms differences, cross products and the hit decision for each pair.
// ----------------------------------------------------------------------------
module segx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  segx_pkg::segx_in_t  in_data_i,
  output logic                push_valid_o,
  input  logic                push_full_i,
  output segx_pkg::segx_job_t push_data_o
);
  import segx_pkg::*;

  logic   en;
  logic   va_q, vb_q, vc_q;
  diff_t  d1x_q, d1y_q, d2x_q, d2y_q, rx_q, ry_q;
  coord_t ax_a_q, ay_a_q, ax_b_q, ay_b_q;
  diff_t  d1x_b_q, d1y_b_q;
  prod_t  p_den1_q, p_den2_q, p_na1_q, p_na2_q, p_nb1_q, p_nb2_q;
  den_t   den, na, nb;
  segx_job_t job_d, job_q;

  assign en         = !vc_q || !push_full_i;
  assign in_stall_o = !en;

  assign den = DenW'(p_den1_q) - DenW'(p_den2_q);
  assign na  = DenW'(p_na1_q) - DenW'(p_na2_q);
  assign nb  = DenW'(p_nb1_q) - DenW'(p_nb2_q);

  always_comb begin
    job_d.parallel = (den == '0);
    job_d.hit      = (den != '0) && in_unit(na, den) && in_unit(nb, den);
    job_d.den      = den;
    job_d.na       = na;
    job_d.d1x      = d1x_b_q;
    job_d.d1y      = d1y_b_q;
    job_d.ax       = ax_b_q;
    job_d.ay       = ay_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1x_q    <= DiffW'(in_data_i.end1_x) - DiffW'(in_data_i.start1_x);
      d1y_q    <= DiffW'(in_data_i.end1_y) - DiffW'(in_data_i.start1_y);
      d2x_q    <= DiffW'(in_data_i.end2_x) - DiffW'(in_data_i.start2_x);
      d2y_q    <= DiffW'(in_data_i.end2_y) - DiffW'(in_data_i.start2_y);
      rx_q     <= DiffW'(in_data_i.start1_x) - DiffW'(in_data_i.start2_x);
      ry_q     <= DiffW'(in_data_i.start1_y) - DiffW'(in_data_i.start2_y);
      ax_a_q   <= in_data_i.start1_x;
      ay_a_q   <= in_data_i.start1_y;
      p_den1_q <= ProdW'(d2y_q) * ProdW'(d1x_q);
      p_den2_q <= ProdW'(d2x_q) * ProdW'(d1y_q);
      p_na1_q  <= ProdW'(d2x_q) * ProdW'(ry_q);
      p_na2_q  <= ProdW'(d2y_q) * ProdW'(rx_q);
      p_nb1_q  <= ProdW'(d1x_q) * ProdW'(ry_q);
      p_nb2_q  <= ProdW'(d1y_q) * ProdW'(rx_q);
      d1x_b_q  <= d1x_q;
      d1y_b_q  <= d1y_q;
      ax_b_q   <= ax_a_q;
      ay_b_q   <= ay_a_q;
      job_q    <= job_d;
    end
  end

  assign push_valid_o = vc_q;
  assign push_data_o  = job_q;

endmodule

// ===== rtl/segx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_queue
// Small first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
module segx_queue #(
  parameter int Depth = segx_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                full_o,
  input  segx_pkg::segx_job_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output segx_pkg::segx_job_t pop_data_o
);
  import segx_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  segx_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/segx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_back
// Crossing point: scaling product, pipelined restoring divide, saturation.
// ----------------------------------------------------------------------------
module segx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  segx_pkg::segx_job_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output segx_pkg::segx_out_t out_data_o
);
  import segx_pkg::*;

  localparam int Stages = QuotW + 1;

  logic en;

  // scaling stage
  logic   vm_q;
  num_t   nx_q, ny_q;
  den_t   den_m_q;
  logic   hit_m_q, par_m_q;
  coord_t ax_m_q, ay_m_q;

  // divide stages, index 0 is the prepared operand
  logic              v_q    [Stages];
  logic [NumW-1:0]   remx_q [Stages];
  logic [NumW-1:0]   remy_q [Stages];
  logic [QuotW-1:0]  qx_q   [Stages];
  logic [QuotW-1:0]  qy_q   [Stages];
  logic [NumW-1:0]   dmag_q [Stages];
  logic              sx_q   [Stages];
  logic              sy_q   [Stages];
  logic              ovx_q  [Stages];
  logic              ovy_q  [Stages];
  logic              hit_q  [Stages];
  logic              par_q  [Stages];
  coord_t            ax_q   [Stages];
  coord_t            ay_q   [Stages];

  logic [NumW-1:0] magx, magy, dmag;
  logic            out_valid_q;
  segx_out_t       out_q, out_d;

  assign en          = !(out_valid_q && out_stall_i);
  assign pop_ready_o = en;

  assign magx = nx_q[NumW-1] ? NumW'(-nx_q) : NumW'(nx_q);
  assign magy = ny_q[NumW-1] ? NumW'(-ny_q) : NumW'(ny_q);
  assign dmag = NumW'(den_m_q[DenW-1] ? DenW'(-den_m_q) : DenW'(den_m_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < Stages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      vm_q   <= pop_valid_i;
      v_q[0] <= vm_q;
      for (int k = 1; k < Stages; k++) begin
        v_q[k] <= v_q[k-1];
      end
      out_valid_q <= v_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q    <= NumW'(pop_data_i.na) * NumW'(pop_data_i.d1x);
      ny_q    <= NumW'(pop_data_i.na) * NumW'(pop_data_i.d1y);
      den_m_q <= pop_data_i.den;
      hit_m_q <= pop_data_i.hit;
      par_m_q <= pop_data_i.parallel;
      ax_m_q  <= pop_data_i.ax;
      ay_m_q  <= pop_data_i.ay;

      remx_q[0] <= magx;
      remy_q[0] <= magy;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dmag_q[0] <= dmag;
      sx_q[0]   <= nx_q[NumW-1] ^ den_m_q[DenW-1];
      sy_q[0]   <= ny_q[NumW-1] ^ den_m_q[DenW-1];
      // quotient too wide for the QuotW-bit quotient register
      ovx_q[0]  <= magx >= (dmag << QuotW);
      ovy_q[0]  <= magy >= (dmag << QuotW);
      hit_q[0]  <= hit_m_q;
      par_q[0]  <= par_m_q;
      ax_q[0]   <= ax_m_q;
      ay_q[0]   <= ay_m_q;

      for (int k = 1; k < Stages; k++) begin
        if (remx_q[k-1] >= (dmag_q[k-1] << (QuotW - k))) begin
          remx_q[k] <= remx_q[k-1] - (dmag_q[k-1] << (QuotW - k));
          qx_q[k]   <= qx_q[k-1] | (QuotW'(1) << (QuotW - k));
        end else begin
          remx_q[k] <= remx_q[k-1];
          qx_q[k]   <= qx_q[k-1];
        end
        if (remy_q[k-1] >= (dmag_q[k-1] << (QuotW - k))) begin
          remy_q[k] <= remy_q[k-1] - (dmag_q[k-1] << (QuotW - k));
          qy_q[k]   <= qy_q[k-1] | (QuotW'(1) << (QuotW - k));
        end else begin
          remy_q[k] <= remy_q[k-1];
          qy_q[k]   <= qy_q[k-1];
        end
        dmag_q[k] <= dmag_q[k-1];
        sx_q[k]   <= sx_q[k-1];
        sy_q[k]   <= sy_q[k-1];
        ovx_q[k]  <= ovx_q[k-1];
        ovy_q[k]  <= ovy_q[k-1];
        hit_q[k]  <= hit_q[k-1];
        par_q[k]  <= par_q[k-1];
        ax_q[k]   <= ax_q[k-1];
        ay_q[k]   <= ay_q[k-1];
      end
      out_q <= out_d;
    end
  end

  function automatic coord_t sat_add(coord_t base, logic [QuotW-1:0] mag, logic neg,
                                     logic ovf, output logic sat);
    logic signed [SumW-1:0] q, s, hi, lo;
    coord_t                 r;
    hi  = {{(SumW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
    lo  = {{(SumW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};
    q   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s   = SumW'(base) + q;
    sat = 1'b1;
    if (ovf) begin
      r = neg ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else if (s > hi) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (s < lo) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r   = s[CoordW-1:0];
      sat = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    logic   satx, saty;
    coord_t px, py;
    px = sat_add(ax_q[Stages-1], qx_q[Stages-1], sx_q[Stages-1], ovx_q[Stages-1], satx);
    py = sat_add(ay_q[Stages-1], qy_q[Stages-1], sy_q[Stages-1], ovy_q[Stages-1], saty);
    out_d.parallel = par_q[Stages-1];
    out_d.hit      = hit_q[Stages-1] && !par_q[Stages-1];
    out_d.cross_x  = par_q[Stages-1] ? '0 : px;
    out_d.cross_y  = par_q[Stages-1] ? '0 : py;
    out_d.clipped  = !par_q[Stages-1] && (satx || saty);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/segment_intersection_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_core
// Exact 2-D segment hit test with saturated crossing point, Q12.4 operands.
// ----------------------------------------------------------------------------
//  channel | valid      | stall       | word
//  --------+------------+-------------+------------------------------
//  in      | in_valid_i | in_stall_o  | in_data_i  (two segments)
//  out     | out_valid_o| out_stall_i | out_data_o (hit, point, flags)
//
//  one pair per cycle sustained while the output is not stalled; a result
//  passes three front stages, the queue, scaling product, operand prep,
//  17 divide stages (one quotient bit each) and the output register.
//  reset clears only the valid and queue state.
//  a stall on the output halts the back part; the front keeps filling the
//  queue and stalls its input once the queue is full.
// ----------------------------------------------------------------------------
module segment_intersection_core #(
  parameter int QueueDepth = segx_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  segx_pkg::segx_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output segx_pkg::segx_out_t out_data_o
);
  import segx_pkg::*;

  logic      push_valid, full, pop_valid, pop_ready;
  segx_job_t push_data, pop_data;

  segx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_full_i  (full),
    .push_data_o  (push_data)
  );

  segx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .full_o       (full),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  segx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/segx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_checker
// Port-level checks for the segment intersection core.
// ----------------------------------------------------------------------------
module segx_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input segx_pkg::segx_out_t out_data_o
);
  import segx_pkg::*;

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // parallel input gives a zero point and no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parallel |->
      !out_data_o.hit && !out_data_o.clipped &&
      out_data_o.cross_x == '0 && out_data_o.cross_y == '0)
    else $error("parallel result not cleared");

  // a hit point lies on segment one, so never saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> !out_data_o.clipped && !out_data_o.parallel)
    else $error("hit with clipped or parallel");

  // the input side only stalls after a result word was held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output back-pressure");

endmodule

bind segment_intersection_core segx_checker u_segx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
